// ----- sv/lkv_pkg.sv -----
// Shared constants, types and helper functions for the LRU key/value cache.
package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int DATA_W      = 32;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

  typedef logic [MAX_ENTRIES-1:0] entry_vec_t;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load_req;
    logic match;
    logic commit;
    logic cfg_write;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [IDX_W-1:0] lowest_set(input entry_vec_t vec);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- sv/lkv_ifs.sv -----
// Handshake channel interfaces for requests, responses and the capacity register.
interface lkv_req_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic signed [31:0]        key;
  logic signed [31:0]        value;
  modport source (output valid, mode, key, value, input ready);
  modport sink (input valid, mode, key, value, output ready);
endinterface

interface lkv_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [31:0]        read_value;
  logic                      evicted;
  modport source (output valid, hit, read_value, evicted, input ready);
  modport sink (input valid, hit, read_value, evicted, output ready);
endinterface

interface lkv_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [4:0]                capacity;
  modport source (output valid, capacity, input ready);
  modport sink (input valid, capacity, output ready);
endinterface

// ----- sv/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key/value cache.
//
//   channel  role    payload                       handshake
//   req      sink    mode, key, value              valid/ready
//   rsp      source  hit, read_value, evicted      valid/ready
//   cfg      sink    capacity                      valid/ready
//
// A request passes three steps: accepting it, the parallel key
// match, and committing the update and loading the response register.
// The commit step waits while the previous response is still held, so a
// stalled rsp channel holds back the next request after at most one.
// A capacity write is taken only between requests and empties the store.
// Reset (synchronous) clears all valid bits, ranks and the entry count and
// sets capacity to 16; no clearing pass is needed.
module lru_key_value_cache (
  input  logic clk,
  input  logic rst,
  lkv_req_if.sink   req,
  lkv_rsp_if.source rsp,
  lkv_cfg_if.sink   cfg
);
  import lkv_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .cfg_valid (cfg.valid),
    .stat      (stat),
    .req_ready (req.ready),
    .cfg_ready (cfg.ready),
    .cmd       (cmd)
  );

  lkv_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .mode           (req.mode),
    .key            (req.key),
    .value          (req.value),
    .capacity       (cfg.capacity),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_hit        (rsp.hit),
    .rsp_read_value (rsp.read_value),
    .rsp_evicted    (rsp.evicted)
  );

endmodule

// ----- sv/lkv_ctrl.sv -----
// Sequencing state machine: accept, match, commit.
module lkv_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          cfg_valid,
  input  lkv_pkg::stat_t stat,
  output logic          req_ready,
  output logic          cfg_ready,
  output lkv_pkg::cmd_t cmd
);
  import lkv_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cfg_ready  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        // A capacity write takes precedence over a request in the same cycle.
        cfg_ready     = 1'b1;
        cmd.cfg_write = cfg_valid;
        req_ready     = !cfg_valid;
        if (req_valid && !cfg_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/lkv_dp.sv -----
// Datapath: request latch, key match array, recency ranks and response register.
module lkv_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  lkv_pkg::cmd_t                      cmd,
  output lkv_pkg::stat_t                     stat,
  input  logic                               mode,
  input  logic signed [lkv_pkg::DATA_W-1:0]  key,
  input  logic signed [lkv_pkg::DATA_W-1:0]  value,
  input  logic [lkv_pkg::CAP_W-1:0]          capacity,
  input  logic                               rsp_ready,
  output logic                               rsp_valid,
  output logic                               rsp_hit,
  output logic signed [lkv_pkg::DATA_W-1:0]  rsp_read_value,
  output logic                               rsp_evicted
);
  import lkv_pkg::*;

  mode_t             req_mode;
  logic [DATA_W-1:0] req_key;
  logic [DATA_W-1:0] req_value;

  logic [DATA_W-1:0] entry_key   [MAX_ENTRIES];
  logic [DATA_W-1:0] entry_value [MAX_ENTRIES];
  logic [IDX_W-1:0]  rank        [MAX_ENTRIES];
  entry_vec_t        entry_valid;
  logic [CNT_W-1:0]  used_count;
  logic [CAP_W-1:0]  cap_reg;

  logic              hit_q;
  logic              full_q;
  logic [IDX_W-1:0]  found_idx;
  entry_vec_t        victim_q;

  entry_vec_t        match_vec;
  entry_vec_t        victim_vec;
  logic [CMP_W-1:0]  eff_cap;
  logic [IDX_W-1:0]  lru_rank;
  logic [IDX_W-1:0]  found_rank;
  entry_vec_t        valid_eff;
  logic [IDX_W-1:0]  slot;

  assign lru_rank   = IDX_W'(used_count - CNT_W'(1));
  assign found_rank = rank[found_idx];

  // Ranks of valid entries are a permutation of 0..used_count-1, so the
  // least recent entry is the one holding the top rank.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_vec[i]  = entry_valid[i] && (entry_key[i] == req_key);
      victim_vec[i] = entry_valid[i] && (rank[i] == lru_rank);
    end
  end

  always_comb begin
    if (cap_reg == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_reg) > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CMP_W'(cap_reg);
    end
  end

  assign valid_eff     = entry_valid & ~(full_q ? victim_q : '0);
  assign slot          = lowest_set(~valid_eff);
  assign stat.out_free = !rsp_valid || rsp_ready;

  // Control state and recency bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      used_count  <= '0;
      cap_reg     <= CAP_RESET;
      rsp_valid   <= 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.cfg_write) begin
        cap_reg     <= capacity;
        entry_valid <= '0;
        used_count  <= '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          rank[i] <= '0;
        end
      end
      if (cmd.commit) begin
        if (hit_q) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (entry_valid[i] && (rank[i] < found_rank)) begin
              rank[i] <= rank[i] + IDX_W'(1);
            end
          end
          rank[found_idx] <= '0;
        end else if (req_mode == MODE_PUT) begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (valid_eff[i]) begin
              rank[i] <= rank[i] + IDX_W'(1);
            end
          end
          entry_valid <= valid_eff | (entry_vec_t'(1) << slot);
          rank[slot]  <= '0;
          if (!full_q) begin
            used_count <= used_count + CNT_W'(1);
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode  <= mode_t'(mode);
      req_key   <= key;
      req_value <= value;
    end
    if (cmd.match) begin
      hit_q     <= |match_vec;
      found_idx <= lowest_set(match_vec);
      victim_q  <= victim_vec;
      full_q    <= CMP_W'(used_count) >= eff_cap;
    end
    if (cmd.commit) begin
      rsp_hit     <= hit_q;
      rsp_evicted <= 1'b0;
      if (hit_q) begin
        if (req_mode == MODE_PUT) begin
          entry_value[found_idx] <= req_value;
          rsp_read_value         <= PUT_VALUE;
        end else begin
          rsp_read_value <= entry_value[found_idx];
        end
      end else if (req_mode == MODE_PUT) begin
        entry_key[slot]   <= req_key;
        entry_value[slot] <= req_value;
        rsp_read_value    <= PUT_VALUE;
        rsp_evicted       <= full_q;
      end else begin
        rsp_read_value <= MISS_VALUE;
      end
    end
  end

endmodule

// ----- tb/sv/tb_lru_key_value_cache.sv -----
// Self-checking testbench for the LRU key/value cache: directed and random requests.
import lkv_pkg::*;

typedef struct packed {
  logic              hit;
  logic [DATA_W-1:0] read_value;
  logic              evicted;
} cache_rsp_t;

class lru_scoreboard;
  logic [DATA_W-1:0] slot_key[MAX_ENTRIES];
  logic [DATA_W-1:0] slot_val[MAX_ENTRIES];
  bit                slot_used[MAX_ENTRIES];
  int unsigned       slot_rank[MAX_ENTRIES];
  int unsigned       n_used;
  logic [CAP_W-1:0]  cap_reg;
  cache_rsp_t        expected_q[$];
  int                errors;

  function new();
    cap_reg = CAP_RESET;
    errors = 0;
    flush();
  endfunction

  function void flush();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_rank[i] = 0;
    end
    n_used = 0;
  endfunction

  function void set_capacity(logic [CAP_W-1:0] c);
    cap_reg = c;
    flush();
  endfunction

  function int unsigned eff_capacity();
    if (cap_reg < 1) return 1;
    if (cap_reg > MAX_ENTRIES) return MAX_ENTRIES;
    return cap_reg;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Entries more recent than the promoted one age by one step.
  function void promote(int e);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (slot_used[i] && slot_rank[i] < slot_rank[e]) slot_rank[i]++;
    end
    slot_rank[e] = 0;
  endfunction

  function void note_request(mode_t m, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
    cache_rsp_t exp;
    int found;
    int victim;
    int free_slot;
    found = -1;
    exp = '{hit: 1'b0, read_value: PUT_VALUE, evicted: 1'b0};
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (found < 0 && slot_used[i] && slot_key[i] == k) found = i;
    end
    exp.hit = (found >= 0);
    if (m == MODE_GET) begin
      if (found >= 0) begin
        exp.read_value = slot_val[found];
        promote(found);
      end else begin
        exp.read_value = MISS_VALUE;
      end
    end else if (found >= 0) begin
      slot_val[found] = v;
      promote(found);
    end else begin
      if (n_used >= eff_capacity()) begin
        victim = -1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_used[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
        end
        if (victim >= 0) begin
          slot_used[victim] = 1'b0;
          slot_rank[victim] = 0;
          if (n_used > 0) n_used--;
          exp.evicted = 1'b1;
        end
      end
      free_slot = -1;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (free_slot < 0 && !slot_used[i]) free_slot = i;
      end
      if (free_slot >= 0) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_used[i]) slot_rank[i]++;
        end
        slot_key[free_slot] = k;
        slot_val[free_slot] = v;
        slot_used[free_slot] = 1'b1;
        slot_rank[free_slot] = 0;
        n_used++;
      end
    end
    expected_q = {expected_q, exp};
  endfunction

  function void check_response(logic h, logic [DATA_W-1:0] rv, logic e);
    cache_rsp_t exp;
    if (expected_q.size() == 0) begin
      $display("%0t: response with no request outstanding: hit %b read_value %h evicted %b",
               $time, h, rv, e);
      errors++;
      return;
    end
    exp = expected_q.pop_front();
    if (h !== exp.hit) begin
      $display("%0t: hit mismatch: expected %b, actual %b", $time, exp.hit, h);
      errors++;
    end
    if (rv !== exp.read_value) begin
      $display("%0t: read_value mismatch: expected %h, actual %h", $time, exp.read_value, rv);
      errors++;
    end
    if (e !== exp.evicted) begin
      $display("%0t: evicted mismatch: expected %b, actual %b", $time, exp.evicted, e);
      errors++;
    end
  endfunction
endclass

module tb_lru_key_value_cache;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          PHASE_ITEMS = 54;

  logic clk;
  logic rst;
  int   idle_pct;
  int   stall_left;
  int unsigned cycle_count;
  lru_scoreboard sb;

  lkv_req_if req_ch ();
  lkv_rsp_if rsp_ch ();
  lkv_cfg_if cfg_ch ();

  lru_key_value_cache i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response side: random stall bursts on ready.
  always @(posedge clk) begin
    if (stall_left == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
      stall_left = $urandom_range(1, 4);
    if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL lru_key_value_cache");
    $finish;
  end

  task automatic send_req(mode_t m, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
    if ($urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= m;
    req_ch.key   <= k;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(m, k, v);
  endtask

  // The store must be drained before the capacity changes.
  task automatic write_capacity(logic [CAP_W-1:0] c);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_capacity(c);
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_random(int n);
    logic [DATA_W-1:0] pool[$];
    int pool_n;
    mode_t m;
    logic [DATA_W-1:0] k;
    pool_n = sb.eff_capacity() + $urandom_range(1, 6);
    for (int i = 0; i < pool_n; i++) begin
      if ($urandom_range(0, 7) == 0) pool = {pool, pick_word()};
      else pool = {pool, DATA_W'($urandom())};
    end
    for (int i = 0; i < n; i++) begin
      m = mode_t'($urandom_range(0, 1));
      // Most requests reuse the key set so hits and evictions are frequent.
      if ($urandom_range(0, 99) < 10) k = $urandom();
      else k = pool[$urandom_range(0, pool_n - 1)];
      send_req(m, k, ($urandom_range(0, 9) == 0) ? pick_word() : $urandom());
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps[8];
    int pcts[8];
    clk = 1'b0;
    rst = 1'b1;
    idle_pct = 25;
    stall_left = 0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_GET;
    req_ch.key = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.capacity = CAP_RESET;
    sb = new();
    caps = '{5'd31, 5'd1, 5'd16, 5'd3, 5'd0, 5'd8, 5'd0, 5'd16};
    caps[4] = $urandom_range(0, 31);
    caps[6] = $urandom_range(0, 31);
    pcts = '{25, 40, 0, 25, 50, 25, 30, 0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset capacity: empty-store miss, extreme keys and values, update on hit.
    send_req(MODE_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(MODE_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_req(MODE_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_req(MODE_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_req(MODE_PUT, 32'h0000_0000, 32'h0000_0000);
    send_req(MODE_GET, 32'h8000_0000, 32'hffff_ffff);
    send_req(MODE_GET, 32'h7fff_ffff, 32'h0000_0000);
    send_req(MODE_GET, 32'hffff_ffff, 32'h0000_0000);
    send_req(MODE_PUT, 32'h0000_0000, 32'h1234_5678);
    send_req(MODE_GET, 32'h0000_0000, 32'h0000_0000);
    send_req(MODE_GET, 32'h0000_0001, 32'h0000_0000);

    // Two entries: a get refreshes recency, so the other one is evicted.
    write_capacity(5'd2);
    send_req(MODE_PUT, 32'd1, 32'd11);
    send_req(MODE_PUT, 32'd2, 32'd22);
    send_req(MODE_GET, 32'd1, 32'd0);
    send_req(MODE_PUT, 32'd3, 32'd33);
    send_req(MODE_GET, 32'd2, 32'd0);
    send_req(MODE_GET, 32'd1, 32'd0);
    send_req(MODE_GET, 32'd3, 32'd0);
    send_req(MODE_PUT, 32'd4, 32'd44);
    send_req(MODE_GET, 32'd1, 32'd0);
    send_req(MODE_PUT, 32'd3, 32'd0);
    send_req(MODE_GET, 32'd3, 32'd0);

    // A capacity of zero behaves as one.
    write_capacity(5'd0);
    send_req(MODE_PUT, 32'd5, 32'd55);
    send_req(MODE_PUT, 32'd6, 32'd66);
    send_req(MODE_GET, 32'd5, 32'd0);
    send_req(MODE_GET, 32'd6, 32'd0);

    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      idle_pct = pcts[p];
      run_random(PHASE_ITEMS);
    end
    req_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS lru_key_value_cache");
    end else begin
      $display("FAIL lru_key_value_cache");
    end
    $finish;
  end
endmodule
